// ===== design/bffa_pkg.sv =====
// Shared constants, codes and types of the bitmap first-fit allocator.
`timescale 1ns / 1ps
`default_nettype none
package bffa_pkg;

  // Map size, kept a power of two so the scan index carries into a done bit
  localparam int NUM_BLOCKS = 64;
  localparam int BLK_W      = $clog2(NUM_BLOCKS);
  localparam int CNT_W      = BLK_W + 1;

  // Transaction field widths
  localparam int FIELD_W = 7;
  localparam int SUM_W   = FIELD_W + 1;

  // Operation codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result when no run fits (-1)
  localparam logic [FIELD_W-1:0] ALLOC_FAIL = {FIELD_W{1'b1}};

  // Occupancy memory access, controller to memory
  typedef struct packed {
    logic             we;
    logic [BLK_W-1:0] waddr;
    logic             wdata;
    logic [BLK_W-1:0] raddr;
  } mem_req_t;

endpackage
`default_nettype wire

// ===== design/bffa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bffa_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== design/bffa_ctrl.sv =====
// Sequencer: clearing pass, first-fit scan, run marking and freeing.
`timescale 1ns / 1ps
`default_nettype none
module bffa_ctrl (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           func_i,
  input  wire logic signed [bffa_pkg::FIELD_W-1:0] start_block_i,
  input  wire logic [bffa_pkg::FIELD_W-1:0]   run_length_i,
  output bffa_pkg::mem_req_t                  mem_req_o,
  input  wire logic                           mem_rdata_i,
  output logic                                push_valid_o,
  output logic [bffa_pkg::FIELD_W-1:0]        push_data_o,
  input  wire logic                           push_ready_i
);
  import bffa_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;
  localparam logic [1:0] ST_PUSH  = 2'd3;

  localparam logic [CNT_W-1:0] NUM_CNT = CNT_W'(NUM_BLOCKS);
  localparam logic [SUM_W-1:0] NUM_SUM = SUM_W'(NUM_BLOCKS);

  logic [1:0]         state_q, state_d;
  logic [CNT_W-1:0]   rd_idx_q, rd_idx_d;
  logic               chk_vld_q, chk_vld_d;
  logic [BLK_W-1:0]   chk_idx_q, chk_idx_d;
  logic [CNT_W-1:0]   run_q, run_d;
  logic [BLK_W-1:0]   first_q, first_d;
  logic [FIELD_W-1:0] len_q, len_d;
  logic [CNT_W-1:0]   wr_idx_q, wr_idx_d;
  logic [CNT_W-1:0]   wr_end_q, wr_end_d;
  logic               wr_bit_q, wr_bit_d;
  logic               push_q, push_d;
  logic [FIELD_W-1:0] res_q, res_d;

  logic [FIELD_W-1:0] start_u;
  logic [SUM_W-1:0]   free_end;
  logic [BLK_W-1:0]   run_first;
  logic               accept;

  assign start_u   = $unsigned(start_block_i);
  assign free_end  = {1'b0, start_u} + {1'b0, run_length_i};
  assign run_first = (run_q == '0) ? chk_idx_q : first_q;
  assign accept    = in_valid_i && !in_stall_o;

  // Next-state logic
  always_comb begin
    state_d   = state_q;
    rd_idx_d  = rd_idx_q;
    chk_vld_d = chk_vld_q;
    chk_idx_d = chk_idx_q;
    run_d     = run_q;
    first_d   = first_q;
    len_d     = len_q;
    wr_idx_d  = wr_idx_q;
    wr_end_d  = wr_end_q;
    wr_bit_d  = wr_bit_q;
    push_d    = push_q;
    res_d     = res_q;

    in_stall_o      = (state_q != ST_IDLE);
    push_valid_o    = 1'b0;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = wr_idx_q[BLK_W-1:0];
    mem_req_o.wdata = wr_bit_q;
    mem_req_o.raddr = rd_idx_q[BLK_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (func_i == FUNC_ALLOC) begin
            len_d = run_length_i;
            if (run_length_i == '0 || {1'b0, run_length_i} > NUM_SUM) begin
              res_d   = ALLOC_FAIL;
              state_d = ST_PUSH;
            end else begin
              rd_idx_d  = '0;
              chk_vld_d = 1'b0;
              run_d     = '0;
              state_d   = ST_SCAN;
            end
          end else if (!start_u[FIELD_W-1] && {1'b0, start_u} < NUM_SUM &&
                       run_length_i != '0) begin
            // Free: clear start onward, clamped at the end of the map
            wr_idx_d = CNT_W'(start_u);
            wr_end_d = (free_end > NUM_SUM) ? NUM_CNT : free_end[CNT_W-1:0];
            wr_bit_d = 1'b0;
            push_d   = 1'b0;
            state_d  = ST_WRITE;
          end
        end
      end

      ST_SCAN: begin
        // Issue one read per cycle; the data comes back in the cycle after
        if (rd_idx_q < NUM_CNT) begin
          rd_idx_d  = rd_idx_q + 1'b1;
          chk_vld_d = 1'b1;
          chk_idx_d = rd_idx_q[BLK_W-1:0];
        end else begin
          chk_vld_d = 1'b0;
        end
        if (chk_vld_q) begin
          if (!mem_rdata_i) begin
            first_d = run_first;
            run_d   = run_q + 1'b1;
            if ((run_q + 1'b1) == CNT_W'(len_q)) begin
              res_d    = FIELD_W'(run_first);
              wr_idx_d = CNT_W'(run_first);
              wr_end_d = CNT_W'(run_first) + CNT_W'(len_q);
              wr_bit_d = 1'b1;
              push_d   = 1'b1;
              state_d  = ST_WRITE;
            end else if (chk_idx_q == BLK_W'(NUM_BLOCKS - 1)) begin
              res_d   = ALLOC_FAIL;
              state_d = ST_PUSH;
            end
          end else begin
            run_d = '0;
            if (chk_idx_q == BLK_W'(NUM_BLOCKS - 1)) begin
              res_d   = ALLOC_FAIL;
              state_d = ST_PUSH;
            end
          end
        end
      end

      ST_WRITE: begin
        // One block per cycle; also serves the clearing pass after reset
        mem_req_o.we = 1'b1;
        wr_idx_d     = wr_idx_q + 1'b1;
        if ((wr_idx_q + 1'b1) == wr_end_q) begin
          state_d = push_q ? ST_PUSH : ST_IDLE;
        end
      end

      ST_PUSH: begin
        push_valid_o = 1'b1;
        if (push_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign push_data_o = res_q;

  // Control registers; reset starts the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_WRITE;
      rd_idx_q  <= '0;
      chk_vld_q <= 1'b0;
      run_q     <= '0;
      wr_idx_q  <= '0;
      wr_end_q  <= NUM_CNT;
      wr_bit_q  <= 1'b0;
      push_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_idx_q  <= rd_idx_d;
      chk_vld_q <= chk_vld_d;
      run_q     <= run_d;
      wr_idx_q  <= wr_idx_d;
      wr_end_q  <= wr_end_d;
      wr_bit_q  <= wr_bit_d;
      push_q    <= push_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    chk_idx_q <= chk_idx_d;
    first_q   <= first_d;
    len_q     <= len_d;
    res_q     <= res_d;
  end

  // Writes stay inside the run being marked or cleared
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.we |-> (wr_idx_q < wr_end_q && wr_end_q <= NUM_CNT))
    else $error("write outside run");

  // No memory writes while scanning
  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !mem_req_o.we)
    else $error("write during scan");

  // A found run fits entirely inside the map
  a_run_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid_o && res_q != ALLOC_FAIL) |->
      ({1'b0, res_q} + {1'b0, len_q} <= NUM_SUM))
    else $error("allocated run overruns map");

  // Zero length allocate fails at once
  a_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func_i == FUNC_ALLOC && run_length_i == '0) |=>
      (state_q == ST_PUSH && res_q == ALLOC_FAIL))
    else $error("zero length allocate not rejected");

  // The scan only checks data for blocks it has read
  a_scan_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && chk_vld_q) |-> (CNT_W'(chk_idx_q) < rd_idx_q))
    else $error("scan check ahead of read");

endmodule
`default_nettype wire

// ===== design/bitmap_first_fit_allocator_unit.sv =====
// Top level of the bitmap first-fit allocator: memory, sequencer, result register.
//
//  channel   direction  transaction fields                      handshake
//  in        input      func_i, start_block_i, run_length_i     in_valid_i / in_stall_o
//  out       output     alloc_start_o (one per allocate only)   out_valid_o / out_stall_i
//
// Allocate: the scan reads one block per cycle from the map RAM; a run that fits is
// then marked block by block, and the result (or -1) is pushed to the output.
// Free: the cleared blocks are written one at a time through the single RAM write port.
// After reset a clearing pass over all NUM_BLOCKS (64) blocks runs with in_stall_o high.
// A waiting result in the output register holds off the next result, and input stalls while that one waits.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_first_fit_allocator_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               func_i,
  input  wire logic signed [bffa_pkg::FIELD_W-1:0] start_block_i,
  input  wire logic [bffa_pkg::FIELD_W-1:0]       run_length_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [bffa_pkg::FIELD_W-1:0]     alloc_start_o
);
  import bffa_pkg::*;

  mem_req_t           mem_req;
  logic               mem_rdata;
  logic               push_valid;
  logic               push_ready;
  logic [FIELD_W-1:0] push_data;
  logic               out_valid_q;
  logic [FIELD_W-1:0] out_data_q;

  // Occupancy map, one bit per block
  bffa_ram #(
    .DEPTH (NUM_BLOCKS),
    .WIDTH (1)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  bffa_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .start_block_i (start_block_i),
    .run_length_i  (run_length_i),
    .mem_req_o     (mem_req),
    .mem_rdata_i   (mem_rdata),
    .push_valid_o  (push_valid),
    .push_data_o   (push_data),
    .push_ready_i  (push_ready)
  );

  // Output register: loads when empty or being drained
  assign push_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push_ready) begin
      out_valid_q <= push_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_valid && push_ready) begin
      out_data_q <= push_data;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign alloc_start_o = $signed(out_data_q);

endmodule
`default_nettype wire
